// File: rtl/core/b64rle_pkg.sv
// ----------------------------------------------------------------------------
// Base64 run-length encoder package
// Shared constants, queue entry types and the base64 alphabet lookup.
// ----------------------------------------------------------------------------
package b64rle_pkg;

   localparam logic OpData = 1'b0;
   localparam logic OpEnd  = 1'b1;

   localparam logic [7:0] RunMark     = 8'h40;
   localparam logic [5:0] RunCap      = 6'd63;
   localparam logic [5:0] RunPlainMax = 6'd3;
   localparam logic [7:0] PadChar     = 8'h3D;

   localparam logic [1:0] GroupFull = 2'd3;

   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // Up to two base64 groups of four characters, in emission order.
   typedef struct packed {
      logic [7:0][7:0] chars;
      logic [1:0]      groups;
      logic            is_end;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   function automatic logic [7:0] alphabet_char(input logic [5:0] idx);
      logic [7:0] wide;
      logic [7:0] ch;
      wide = {2'b00, idx};
      priority if (idx < 6'd26) begin
         ch = wide + 8'd65;
      end else if (idx < 6'd52) begin
         ch = wide + 8'd71;
      end else if (idx < 6'd62) begin
         ch = wide - 8'd4;
      end else if (idx == 6'd62) begin
         ch = 8'h2B;
      end else begin
         ch = 8'h2F;
      end
      return ch;
   endfunction

   // Encodes n (1 to 3) bytes as four characters with '=' padding.
   function automatic logic [3:0][7:0] encode_group(input logic [7:0] b0,
                                                    input logic [7:0] b1,
                                                    input logic [7:0] b2,
                                                    input logic [1:0] n);
      logic [23:0]     g;
      logic [3:0][7:0] c;
      g    = {b0, (n > 2'd1) ? b1 : 8'h00, (n > 2'd2) ? b2 : 8'h00};
      c[0] = alphabet_char(g[23:18]);
      c[1] = alphabet_char(g[17:12]);
      c[2] = (n > 2'd1) ? alphabet_char(g[11:6]) : PadChar;
      c[3] = (n > 2'd2) ? alphabet_char(g[5:0]) : PadChar;
      return c;
   endfunction

endpackage

// File: rtl/core/b64rle_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one data or end word into the encoder.
// ----------------------------------------------------------------------------
interface b64rle_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] word;

   modport source(output valid, output op, output word, input ready);
   modport sink(input valid, input op, input word, output ready);
endinterface

// File: rtl/core/b64rle_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one encoded character out of the encoder.
// ----------------------------------------------------------------------------
interface b64rle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       is_last;

   modport source(output valid, output out_char, output is_last, input ready);
   modport sink(input valid, input out_char, input is_last, output ready);
endinterface

// File: rtl/core/b64rle_front.sv
// ----------------------------------------------------------------------------
// Encoder front end
// Accepts words, joins them with the pending bytes and turns every full
// three-byte group into four base64 characters for the queue, padding at end.
// ----------------------------------------------------------------------------
module b64rle_front (
   input  logic                 clock,
   input  logic                 reset,
   b64rle_req_if.sink           req_bus,
   input  logic                 queue_full,
   output b64rle_pkg::push_type push
);
   import b64rle_pkg::*;

   logic [15:0]     pend_bytes_ff, pend_bytes_in;
   logic [1:0]      pend_cnt_ff, pend_cnt_in;
   logic [5:0][7:0] bytes;
   logic [3:0][7:0] grp_lo, grp_hi, grp_end;
   logic            accept;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      unique case (pend_cnt_ff)
         2'd0:    bytes = {16'h0000, req_bus.word};
         2'd1:    bytes = {8'h00, req_bus.word, pend_bytes_ff[7:0]};
         default: bytes = {req_bus.word, pend_bytes_ff};
      endcase
   end

   assign grp_lo  = encode_group(bytes[0], bytes[1], bytes[2], GroupFull);
   assign grp_hi  = encode_group(bytes[3], bytes[4], bytes[5], GroupFull);
   assign grp_end = encode_group(pend_bytes_ff[7:0], pend_bytes_ff[15:8], 8'h00,
                                 pend_cnt_ff);

   always_comb begin
      pend_bytes_in     = pend_bytes_ff;
      pend_cnt_in       = pend_cnt_ff;
      push.valid        = accept;
      push.entry.chars  = {grp_hi, grp_lo};
      push.entry.groups = 2'd1;
      push.entry.is_end = 1'b0;
      if (req_bus.op == OpEnd) begin
         push.entry.chars  = {32'h0000_0000, grp_end};
         push.entry.groups = (pend_cnt_ff != 2'd0) ? 2'd1 : 2'd0;
         push.entry.is_end = 1'b1;
         pend_bytes_in     = 16'h0000;
         pend_cnt_in       = 2'd0;
      end else begin
         unique case (pend_cnt_ff)
            2'd0: begin
               pend_bytes_in = {8'h00, bytes[3]};
               pend_cnt_in   = 2'd1;
            end
            2'd1: begin
               pend_bytes_in = {bytes[4], bytes[3]};
               pend_cnt_in   = 2'd2;
            end
            default: begin
               // Six bytes make exactly two groups and nothing is left over.
               push.entry.groups = 2'd2;
               pend_bytes_in     = 16'h0000;
               pend_cnt_in       = 2'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bytes_ff <= 16'h0000;
         pend_cnt_ff   <= 2'd0;
      end else if (accept) begin
         pend_bytes_ff <= pend_bytes_in;
         pend_cnt_ff   <= pend_cnt_in;
      end
   end

endmodule

// File: rtl/core/b64rle_queue.sv
// ----------------------------------------------------------------------------
// Encoder character queue
// Short FIFO of character groups between the front end and the run stage.
// ----------------------------------------------------------------------------
module b64rle_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  b64rle_pkg::push_type push,
   output logic                 full,
   output b64rle_pkg::head_type head,
   input  logic                 pop
);
   import b64rle_pkg::*;

   entry_type              fifo_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;

   function automatic logic [QueuePtrW-1:0] next_ptr(input logic [QueuePtrW-1:0] ptr);
      logic [QueuePtrW-1:0] nxt;
      if (ptr == QueuePtrW'(QueueDepth - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + QueuePtrW'(1);
      end
      return nxt;
   endfunction

   assign full       = (count_ff == QueueCntW'(QueueDepth));
   assign head.valid = (count_ff != '0);
   assign head.entry = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.valid ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + QueueCntW'(1);
      end else if (!push.valid && pop) begin
         count_in = count_ff - QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         fifo_ff[wr_ptr_ff] <= push.entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntW'(QueueDepth))
      else $error("queue count beyond depth");
`endif

endmodule

// File: rtl/core/b64rle_back.sv
// ----------------------------------------------------------------------------
// Encoder run stage
// Walks the queued characters one per cycle while the output is free and no
// run drains, counts runs and emits closed runs via the response register.
// ----------------------------------------------------------------------------
module b64rle_back (
   input  logic                 clock,
   input  logic                 reset,
   input  b64rle_pkg::head_type head,
   output logic                 pop,
   b64rle_rsp_if.source         rsp_bus
);
   import b64rle_pkg::*;

   logic            run_open_ff, run_open_in;
   logic [7:0]      run_char_ff, run_char_in;
   logic [5:0]      run_len_ff, run_len_in;
   logic [2:0]      idx_ff, idx_in;
   logic [1:0][7:0] rem_ff, rem_in;
   logic [1:0]      rem_cnt_ff, rem_cnt_in;
   logic            rem_last_ff, rem_last_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_char_ff, rsp_char_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            out_free;
   logic [3:0]      nchar;
   logic [7:0]      cur;
   logic            extend;
   logic [7:0]      close_first;
   logic [1:0][7:0] close_rem;
   logic [1:0]      close_cnt;
   logic            emit;
   logic [7:0]      emit_char;
   logic            emit_last;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign nchar    = {head.entry.groups, 2'b00};
   assign cur      = head.entry.chars[idx_ff];
   assign extend   = run_open_ff && (run_char_ff == cur) && (run_len_ff != RunCap);

   // A long run leaves as mark, character, count; a short one as copies.
   always_comb begin
      if (run_len_ff > RunPlainMax) begin
         close_first = RunMark;
         close_rem   = {alphabet_char(run_len_ff), run_char_ff};
         close_cnt   = 2'd2;
      end else begin
         close_first = run_char_ff;
         close_rem   = {run_char_ff, run_char_ff};
         close_cnt   = run_len_ff[1:0] - 2'd1;
      end
   end

   always_comb begin
      run_open_in  = run_open_ff;
      run_char_in  = run_char_ff;
      run_len_in   = run_len_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      rem_cnt_in   = rem_cnt_ff;
      rem_last_in  = rem_last_ff;
      pop          = 1'b0;
      emit         = 1'b0;
      emit_char    = 8'h00;
      emit_last    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         priority if (rem_cnt_ff != 2'd0) begin
            emit       = 1'b1;
            emit_char  = rem_ff[0];
            emit_last  = rem_last_ff && (rem_cnt_ff == 2'd1);
            rem_in     = {8'h00, rem_ff[1]};
            rem_cnt_in = rem_cnt_ff - 2'd1;
         end else if (head.valid) begin
            if ({1'b0, idx_ff} < nchar) begin
               if (extend) begin
                  run_len_in = run_len_ff + 6'd1;
               end else begin
                  if (run_open_ff) begin
                     emit        = 1'b1;
                     emit_char   = close_first;
                     rem_in      = close_rem;
                     rem_cnt_in  = close_cnt;
                     rem_last_in = 1'b0;
                  end
                  run_open_in = 1'b1;
                  run_char_in = cur;
                  run_len_in  = 6'd1;
               end
               idx_in = idx_ff + 3'd1;
               // A data entry leaves the queue with its last character.
               if (({1'b0, idx_ff} + 4'd1 == nchar) && !head.entry.is_end) begin
                  pop    = 1'b1;
                  idx_in = 3'd0;
               end
            end else begin
               // End entry: close the open run and mark its final character.
               if (run_open_ff) begin
                  emit        = 1'b1;
                  emit_char   = close_first;
                  emit_last   = (close_cnt == 2'd0);
                  rem_in      = close_rem;
                  rem_cnt_in  = close_cnt;
                  rem_last_in = 1'b1;
               end
               run_open_in = 1'b0;
               run_char_in = 8'h00;
               run_len_in  = 6'd0;
               pop         = 1'b1;
               idx_in      = 3'd0;
            end
         end
         rsp_valid_in = emit;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff  <= 1'b0;
         run_char_ff  <= 8'h00;
         run_len_ff   <= 6'd0;
         idx_ff       <= 3'd0;
         rem_cnt_ff   <= 2'd0;
         rem_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_open_ff  <= run_open_in;
         run_char_ff  <= run_char_in;
         run_len_ff   <= run_len_in;
         idx_ff       <= idx_in;
         rem_cnt_ff   <= rem_cnt_in;
         rem_last_ff  <= rem_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_char = rsp_char_ff;
   assign rsp_bus.is_last  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_run_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      run_open_ff |-> (run_len_ff != 6'd0))
      else $error("open run with zero length");
   a_drain_before_pop: assert property (@(posedge clock) disable iff (reset)
      (rem_cnt_ff != 2'd0) |-> !pop)
      else $error("entry released while a run is still being emitted");
   a_last_closes_all: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (!run_open_ff && (rem_cnt_ff == 2'd0)))
      else $error("last character shown while output remains");
`endif

endmodule

// File: rtl/core/base64_run_length_encoder.sv
// ----------------------------------------------------------------------------
// Base64 run-length encoder
// Encodes 32-bit words as base64 characters, then run-length codes them.
// ----------------------------------------------------------------------------
// Usage: req_bus takes one word per handshake; op selects a data word (bytes
// low first) or the end of the stream. rsp_bus returns the encoded
// characters one per handshake, with is_last set on the final character of
// an end word. An end word with nothing pending and no open run yields none.
// A character that closes a run passes through the queue and then the response
// register; characters held in an open run leave later.
// Throughput: the run stage walks the base64 characters one per cycle while
// the output is free (four or eight per data word, four or none for an end
// word); it also closes the run at an end word, and it waits while each
// further character of a closed run (mark, character, count) leaves.
// A two-entry queue lets the front accept words while the run stage is busy.
// Reset clears the pending bytes, the open run and the queue.
// When the receiver stalls, the output register holds its character and
// the run stage waits; the front fills the queue and then drops ready.
// ----------------------------------------------------------------------------
module base64_run_length_encoder (
   input  logic         clock,
   input  logic         reset,
   b64rle_req_if.sink   req_bus,
   b64rle_rsp_if.source rsp_bus
);
   import b64rle_pkg::*;

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   b64rle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push)
   );

   b64rle_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   b64rle_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// File: bench/b64rle_checker.sv
// ----------------------------------------------------------------------------
// Base64 run-length encoder checker
// Watches both channels of the encoder. Every accepted word is run through a
// base64 and run-length encoder of its own, and every character that
// leaves the block is compared with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module b64rle_checker (
   input  logic   clock,
   input  logic   reset,
   b64rle_req_if  req_mon,
   b64rle_rsp_if  rsp_mon,
   output int     failures,
   output int     pending_chars,
   output int     chars_checked,
   output int     words_seen,
   output int     end_words,
   output int     capped_runs,
   output int     marked_runs
);
   import b64rle_pkg::*;

   localparam logic [64*8-1:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } enc_char_type;

   enc_char_type expected_chars[$];

   // Encoder state as seen from the outside
   logic [15:0] held_bytes;
   logic [1:0]  held_count;
   logic        run_active;
   logic [7:0]  run_sym;
   logic [5:0]  run_count;

   function automatic logic [7:0] b64_symbol(input logic [5:0] idx);
      return B64_ALPHABET[(63 - int'(idx)) * 8 +: 8];
   endfunction

   task automatic expect_char(input logic [7:0] c);
      enc_char_type e;
      e.ch   = c;
      e.last = 1'b0;
      expected_chars.push_back(e);
   endtask

   task automatic flush_run();
      int k;
      if (run_active) begin
         if (run_count > RunPlainMax) begin
            expect_char(RunMark);
            expect_char(run_sym);
            expect_char(b64_symbol(run_count));
            marked_runs++;
         end else begin
            for (k = 0; k < int'(run_count); k++) expect_char(run_sym);
         end
      end
      run_active = 1'b0;
      run_count  = '0;
   endtask

   task automatic push_symbol(input logic [7:0] c);
      if (run_active && run_sym == c && run_count < RunCap) begin
         run_count++;
      end else begin
         if (run_active && run_sym == c) capped_runs++;
         flush_run();
         run_active = 1'b1;
         run_sym    = c;
         run_count  = 6'd1;
      end
   endtask

   task automatic encode_triplet(input logic [7:0] b0, input logic [7:0] b1,
                                 input logic [7:0] b2, input logic [1:0] n);
      logic [23:0] g;
      g = {b0, (n > 2'd1) ? b1 : 8'h00, (n > 2'd2) ? b2 : 8'h00};
      push_symbol(b64_symbol(g[23:18]));
      push_symbol(b64_symbol(g[17:12]));
      push_symbol((n > 2'd1) ? b64_symbol(g[11:6]) : PadChar);
      push_symbol((n > 2'd2) ? b64_symbol(g[5:0]) : PadChar);
   endtask

   task automatic predict_word(input logic op, input logic [31:0] w);
      logic [7:0]   stream [0:5];
      int           n;
      int           pos;
      int           i;
      int           queued;
      enc_char_type tail;
      n      = 0;
      pos    = 0;
      queued = expected_chars.size();
      for (i = 0; i < 6; i++) stream[i] = 8'h00;
      for (i = 0; i < int'(held_count); i++) begin
         stream[n] = held_bytes[8*i +: 8];
         n++;
      end
      if (op == OpData) begin
         for (i = 0; i < 4; i++) begin
            stream[n] = w[8*i +: 8];
            n++;
         end
         while (n - pos >= 3) begin
            encode_triplet(stream[pos], stream[pos+1], stream[pos+2], GroupFull);
            pos += 3;
         end
         held_bytes = '0;
         held_count = 2'(n - pos);
         for (i = 0; pos + i < n; i++) held_bytes[8*i +: 8] = stream[pos+i];
      end else begin
         end_words++;
         if (n > 0) encode_triplet(stream[0], stream[1], stream[2], 2'(n));
         held_bytes = '0;
         held_count = '0;
         flush_run();
         run_sym = '0;
         // The final character of an end word carries the last flag.
         if (expected_chars.size() > queued) begin
            tail      = expected_chars.pop_back();
            tail.last = 1'b1;
            expected_chars.push_back(tail);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_chars.delete();
         held_bytes = '0;
         held_count = '0;
         run_active = 1'b0;
         run_sym    = '0;
         run_count  = '0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected character %h (last %b)", $time,
                        rsp_mon.out_char, rsp_mon.is_last);
               failures++;
            end else begin
               enc_char_type e;
               e = expected_chars.pop_front();
               if (rsp_mon.out_char !== e.ch) begin
                  $display("%0t: out_char expected %h actual %h", $time,
                           e.ch, rsp_mon.out_char);
                  failures++;
               end
               if (rsp_mon.is_last !== e.last) begin
                  $display("%0t: is_last expected %b actual %b", $time,
                           e.last, rsp_mon.is_last);
                  failures++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            words_seen++;
            predict_word(req_mon.op, req_mon.word);
         end
      end
      pending_chars = expected_chars.size();
   end

   initial begin
      failures      = 0;
      pending_chars = 0;
      chars_checked = 0;
      words_seen    = 0;
      end_words     = 0;
      capped_runs   = 0;
      marked_runs   = 0;
   end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Base64 run-length encoder testbench
// Drives data and end words into the encoder with random gaps, pulls the
// characters out with random stalls and one long hold-off, and lets the
// checker compare every character. Directed cases come first, then random
// streams that favor long runs of one character.
// ----------------------------------------------------------------------------
module testbench;
   import b64rle_pkg::*;

   localparam int RANDOM_ITEMS = 260;
   localparam int HOLD_AT      = 120;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   logic clock = 1'b0;
   logic reset;

   int   cycle_count = 0;
   int   items_sent  = 0;
   logic req_quiet   = 1'b0;
   logic rsp_quiet   = 1'b0;

   int failures;
   int pending_chars;
   int chars_checked;
   int words_seen;
   int end_words;
   int capped_runs;
   int marked_runs;

   b64rle_req_if req_bus();
   b64rle_rsp_if rsp_bus();

   base64_run_length_encoder DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   b64rle_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .failures      (failures),
      .pending_chars (pending_chars),
      .chars_checked (chars_checked),
      .words_seen    (words_seen),
      .end_words     (end_words),
      .capped_runs   (capped_runs),
      .marked_runs   (marked_runs)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Offers one word and returns at the edge where it is taken.
   task automatic send_word(input logic op, input logic [31:0] w);
      int gap;
      if ($urandom_range(0, 14) == 0) req_quiet = !req_quiet;
      gap = req_quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op    <= op;
      req_bus.word  <= w;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // Receiver: a random stall before each character, one long hold-off.
   initial begin
      int   stall;
      logic hold_done;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if ($urandom_range(0, 29) == 0) rsp_quiet = !rsp_quiet;
            stall = rsp_quiet ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin
      int          style;
      int          seq_len;
      int          k;
      logic [31:0] fill;
      logic [31:0] w;
      logic [7:0]  b;
      req_bus.valid <= 1'b0;
      req_bus.op    <= OpData;
      req_bus.word  <= '0;
      reset         <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // An end word with nothing pending yields no character.
      send_word(OpEnd, 32'hFFFF_FFFF);
      // One leftover byte, padded with two '=' characters.
      send_word(OpData, 32'hFFFF_FFFF);
      send_word(OpEnd, 32'h0000_0000);
      // Two leftover bytes, one '=' character.
      send_word(OpData, 32'h1234_5678);
      send_word(OpData, 32'h9ABC_DEF0);
      send_word(OpEnd, $urandom());
      // Whole groups only: the end word just closes the open run.
      send_word(OpData, 32'h0403_0201);
      send_word(OpData, 32'h8040_2010);
      send_word(OpData, 32'hFEDC_BA98);
      send_word(OpEnd, $urandom());
      // Sixty-four 'A' characters in a row overrun the run cap.
      for (k = 0; k < 12; k++) send_word(OpData, 32'h0000_0000);
      send_word(OpEnd, $urandom());

      while (items_sent < RANDOM_ITEMS) begin
         style = $urandom_range(0, 9);
         if (style == 0) begin
            send_word(OpEnd, $urandom());
         end else if (style <= 3) begin
            // Long stretch of one byte value, so runs reach and pass the cap.
            fill    = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            seq_len = $urandom_range(2, 24);
            for (k = 0; k < seq_len; k++)
               send_word(OpData, ($urandom_range(0, 9) == 0) ? $urandom() : fill);
            send_word(OpEnd, $urandom());
         end else begin
            seq_len = $urandom_range(1, 8);
            for (k = 0; k < seq_len; k++) begin
               b = 8'($urandom());
               case ($urandom_range(0, 5))
                  0:       w = 32'h0000_0000;
                  1:       w = 32'hFFFF_FFFF;
                  2:       w = {4{b}};
                  3:       w = 32'(b) << (8 * $urandom_range(0, 3));
                  default: w = $urandom();
               endcase
               send_word(OpData, w);
            end
            send_word(OpEnd, $urandom());
         end
      end
      send_word(OpEnd, $urandom());
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (pending_chars != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words, %0d of them end words; checked %0d characters.",
               words_seen, end_words, chars_checked);
      $display("Runs coded with a mark: %0d; runs split at the length cap: %0d.",
               marked_runs, capped_runs);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/b64rle_pkg.sv
rtl/core/b64rle_req_if.sv
rtl/core/b64rle_rsp_if.sv
rtl/core/b64rle_front.sv
rtl/core/b64rle_queue.sv
rtl/core/b64rle_back.sv
rtl/core/base64_run_length_encoder.sv
bench/b64rle_checker.sv
bench/testbench.sv
